### hw/rtl/brms_pkg.sv
// Shared package for the block RMS level meter.
// Holds parameter defaults, the controller state type and the command struct.
// No dependencies.
package brms_pkg;

   localparam int MAX_FRAMES_DEF  = 65536;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int IN_W            = 24;
   localparam int RMS_W           = 24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_DIVIDE,
      ST_ROOT,
      ST_DONE
   } brms_state_type;

   typedef struct packed {
      logic accum;
      logic start;
      logic div_step;
      logic root_step;
      logic emit;
   } brms_cmd_type;

endpackage

### hw/rtl/brms_ctrl.sv
// Controller for the block RMS level meter: input handshake, step counting
// and sequencing of the divide and square-root passes.
// Depends on brms_pkg.
module brms_ctrl #(
   parameter int DIV_STEPS  = 63,
   parameter int ROOT_STEPS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  logic                out_free,
   output brms_pkg::brms_cmd_type cmd
);
   import brms_pkg::*;

   localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

   brms_state_type    state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            cmd.start = 1'b1;
            cnt_in    = DIV_LAST;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = ROOT_LAST;
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            // Wait until the output register is empty or being drained.
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/brms_dp.sv
// Datapath for the block RMS level meter: sample squaring, sum and count,
// a restoring divider, a digit-by-digit square root and the output register.
// Depends on brms_pkg.
module brms_dp #(
   parameter int MAX_FRAMES  = 65536,
   parameter int SAMPLE_BITS = 24,
   parameter int CNT_W       = 17,
   parameter int SUM_W       = 63,
   parameter int ROOT_W      = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  brms_pkg::brms_cmd_type       cmd,
   input  logic [brms_pkg::IN_W-1:0]    req_sample,
   output logic                         out_free,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [brms_pkg::RMS_W-1:0]   rsp_rms,
   output logic                         rsp_overflow
);
   import brms_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int NUM_W = 2 * ROOT_W;

   // Accumulator.
   logic [SB-1:0]    raw, mag;
   logic [2*SB-1:0]  sq_ff, sq_in;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             full;

   // Divider and square root.
   logic [NUM_W-1:0] num_ff, num_in;
   logic [CNT_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [CNT_W:0]   shifted, diff;
   logic             qbit;
   logic [ROOT_W-1:0] srem_ff, srem_in, root_ff, root_in;
   logic [ROOT_W+1:0] cur, trial, sdiff;
   logic             ge;
   logic             hold_ovf_ff, hold_ovf_in, zero_ff, zero_in;

   // Output register.
   logic             vld_ff, vld_in;
   logic [RMS_W-1:0] rms_ff, rms_in;
   logic             rovf_ff, rovf_in;

   assign raw  = req_sample[SB-1:0];
   // The most negative value maps onto the sign bit, which is its magnitude.
   assign mag  = raw[SB-1] ? (~raw + 1'b1) : raw;
   assign full = (count_ff == CNT_W'(MAX_FRAMES));
   assign sum_next = sum_ff + SUM_W'(sq_ff);

   always_comb begin
      sq_in    = '0;
      sum_in   = sum_next;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.accum) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            sq_in    = mag * mag;
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.start) begin
         sum_in   = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff    <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sq_ff    <= sq_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Divider step: shift one dividend bit into the remainder, quotient bit out.
   assign shifted = {rem_ff, num_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign qbit    = ~diff[CNT_W];

   // Root step: bring down two bits of the quotient and try root*4+1.
   assign cur   = {srem_ff, num_ff[NUM_W-1:NUM_W-2]};
   assign trial = {root_ff, 2'b01};
   assign sdiff = cur - trial;
   assign ge    = ~sdiff[ROOT_W+1];

   always_comb begin
      num_in      = num_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      srem_in     = srem_ff;
      root_in     = root_ff;
      hold_ovf_in = hold_ovf_ff;
      zero_in     = zero_ff;
      if (cmd.start) begin
         num_in      = NUM_W'(sum_next);
         rem_in      = '0;
         div_in      = count_ff;
         srem_in     = '0;
         root_in     = '0;
         hold_ovf_in = ovf_ff;
         zero_in     = (count_ff == '0);
      end else if (cmd.div_step) begin
         num_in = NUM_W'({num_ff[SUM_W-2:0], qbit});
         rem_in = qbit ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      end else if (cmd.root_step) begin
         num_in  = {num_ff[NUM_W-3:0], 2'b00};
         srem_in = ge ? sdiff[ROOT_W-1:0] : cur[ROOT_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      hold_ovf_ff <= hold_ovf_in;
      zero_ff     <= zero_in;
   end

   assign out_free = ~vld_ff | rsp_ready;

   always_comb begin
      vld_in  = vld_ff & ~rsp_ready;
      rms_in  = rms_ff;
      rovf_in = rovf_ff;
      if (cmd.emit) begin
         vld_in  = 1'b1;
         rms_in  = zero_ff ? '0 : (RMS_W'(root_ff[SB-1:0]) << (RMS_W - SB));
         rovf_in = hold_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      rms_ff  <= rms_in;
      rovf_ff <= rovf_in;
   end

   assign rsp_valid    = vld_ff;
   assign rsp_rms      = rms_ff;
   assign rsp_overflow = rovf_ff;

endmodule

### hw/rtl/block_rms_level.sv
// Block RMS level meter, top level. Samples without the last flag are taken one per cycle.
// The last sample of a block starts a pass: a load step, a one-bit-per-cycle divider, a
// two-bits-per-cycle square root and a result load that waits while an earlier result is
// still held. The result is valid, and the input ready again, when the pass ends.
// Synchronous active-high reset clears the sum, the count, the overflow flag and the result
// valid flag. Depends on brms_pkg, brms_ctrl and brms_dp.
module block_rms_level #(
   parameter int MAX_FRAMES  = brms_pkg::MAX_FRAMES_DEF,
   parameter int SAMPLE_BITS = brms_pkg::SAMPLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [brms_pkg::IN_W-1:0]   req_sample,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [brms_pkg::RMS_W-1:0]  rsp_rms,
   output logic                        rsp_overflow
);
   import brms_pkg::*;

   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FRAMES);
   localparam int ROOT_W = (SUM_W + 1) / 2;

   brms_cmd_type cmd;
   logic         out_free;

   brms_ctrl #(
      .DIV_STEPS  (SUM_W),
      .ROOT_STEPS (ROOT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   brms_dp #(
      .MAX_FRAMES  (MAX_FRAMES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W),
      .ROOT_W      (ROOT_W)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_sample   (req_sample),
      .out_free     (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_rms      (rsp_rms),
      .rsp_overflow (rsp_overflow)
   );

   // A last item hands the block to the divide pass.
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("input still ready after the last item of a block");

   // Ordinary items stream without a gap.
   a_stream: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last |=> req_ready)
      else $error("input stalled after an item without the last flag");

   // A new result only appears when the controller loads it.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("result valid rose without an emit command");

   // The root of a mean of squares never exceeds full scale.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rms <= 24'h800000)
      else $error("rms result above full scale");

endmodule
